@@ rtl/core/esd_pkg.sv @@
// Shared types, character codes and helpers of the escape sequence decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package esd_pkg;

	// Parser states.
	typedef enum logic [2:0] {
		MODE_PLAIN,
		MODE_ESC,
		MODE_CARET,
		MODE_OCT,
		MODE_HEX0,
		MODE_HEX1
	} mode_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE_ADDS_CR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CARET_ENABLE    = 2'd1;

	// Source characters.
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_LC_A      = "a";
	localparam logic [7:0] CH_LC_B      = "b";
	localparam logic [7:0] CH_LC_E      = "e";
	localparam logic [7:0] CH_LC_F      = "f";
	localparam logic [7:0] CH_LC_N      = "n";
	localparam logic [7:0] CH_LC_R      = "r";
	localparam logic [7:0] CH_LC_T      = "t";
	localparam logic [7:0] CH_LC_V      = "v";
	localparam logic [7:0] CH_LC_X      = "x";
	localparam logic [7:0] CH_QUOTE     = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;

	// Control codes produced.
	localparam logic [7:0] CC_BEL  = 8'h07;
	localparam logic [7:0] CC_BS   = 8'h08;
	localparam logic [7:0] CC_TAB  = 8'h09;
	localparam logic [7:0] CC_LF   = 8'h0A;
	localparam logic [7:0] CC_VT   = 8'h0B;
	localparam logic [7:0] CC_FF   = 8'h0C;
	localparam logic [7:0] CC_CR   = 8'h0D;
	localparam logic [7:0] CC_ESC  = 8'h1B;
	localparam logic [7:0] CC_NUL  = 8'h00;
	localparam logic [7:0] CTRL_MASK = 8'h1F;

	// Widths of the digit accumulator.
	localparam int unsigned DIGIT_VALUE_W = 9;
	localparam int unsigned DIGIT_COUNT_W = 2;

	// At most three output beats follow from one input beat.
	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned RES_CNT_W   = 2;

	// Output queue geometry.
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       term;
	} entry_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]         count;
		entry_t [MAX_RESULTS-1:0]     slot;
	} result_t;

	// Octal digit test: '0' to '7'.
	function automatic logic is_octal(input logic [7:0] b);
		return b[7:3] == 5'b00110;
	endfunction

	// Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= "0" && b <= "9") begin
			r = {1'b1, b[3:0]};
		end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/escape_sequence_decoder.sv @@
// Top level of the escape sequence decoder: configuration registers, parser
// and output queue. Depends on esd_pkg, esd_decode and esd_queue.
//
// Usage. Source text enters one byte per beat on the in_ channel (valid and
// ready); in_last marks the final byte of a string. Translated bytes leave
// one per beat on the out_ channel. out_run_end marks the last output beat
// caused by one input beat, and out_terminator marks the closing NUL that
// every string ends with. One input beat gives zero to three output beats.
//
// Timing. An accepted byte is parsed in the cycle it is taken; its results
// go straight into an eight-entry output queue, which offers them on out_
// behind earlier entries. The input takes one beat per cycle whenever the
// queue has room for three entries; the output delivers one beat per cycle
// while out_ready is high and the queue is not empty. The queue depth sets
// how long a burst of multi-byte expansions can run before in_ready drops.
//
// Reset (arst_n low) returns the parser to plain text, empties the queue
// and sets both configuration bits to one. When the receiver stalls, the
// queue fills and in_ready falls once fewer than three entries are free;
// nothing is lost. Configuration writes take effect at the clock edge at
// which cfg_wr_en is high and must only be made while the block is idle.
`default_nettype none

module escape_sequence_decoder (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       in_byte,
	input  wire logic                             in_last,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            out_byte,
	output logic                                  out_run_end,
	output logic                                  out_terminator,
	input  wire logic                             cfg_wr_en,
	input  wire logic [esd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic                             cfg_data
);
	import esd_pkg::*;

	// Configuration bits.
	logic    newline_adds_cr_q;
	logic    caret_enable_q;

	logic    accept;
	result_t res;
	entry_t  head;
	logic    room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newline_adds_cr_q <= 1'b1;
			caret_enable_q    <= 1'b1;
		end else if (cfg_wr_en) begin
			// Indexes beyond the register list are ignored.
			unique case (cfg_index)
				CFG_NEWLINE_ADDS_CR: newline_adds_cr_q <= cfg_data;
				CFG_CARET_ENABLE:    caret_enable_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The queue always keeps space for the largest expansion of one beat.
	assign in_ready = room;
	assign accept   = in_valid && in_ready;

	esd_decode u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.in_byte         (in_byte),
		.in_last         (in_last),
		.newline_adds_cr (newline_adds_cr_q),
		.caret_enable    (caret_enable_q),
		.res             (res)
	);

	esd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res),
		.room   (room),
		.valid  (out_valid),
		.ready  (out_ready),
		.head   (head)
	);

	assign out_byte       = head.data;
	assign out_run_end    = head.run_end;
	assign out_terminator = head.term;

endmodule

`default_nettype wire

@@ rtl/core/esd_decode.sv @@
// Parser of the escape sequence decoder: holds the parse state and turns one
// input beat into up to three result entries. Depends on esd_pkg.
`default_nettype none

module esd_decode (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       in_byte,
	input  wire logic             in_last,
	input  wire logic             newline_adds_cr,
	input  wire logic             caret_enable,
	output esd_pkg::result_t      res
);
	import esd_pkg::*;

	mode_t                     mode_q;
	logic [DIGIT_VALUE_W-1:0]  dval_q;
	logic [DIGIT_COUNT_W-1:0]  dcnt_q;

	mode_t                     mode_d;
	logic [DIGIT_VALUE_W-1:0]  dval_d;
	logic [DIGIT_COUNT_W-1:0]  dcnt_d;

	always_comb begin
		logic [RES_CNT_W-1:0] n;
		logic                 do_plain;
		logic [4:0]           hx;
		logic [DIGIT_VALUE_W-1:0] acc;

		n        = '0;
		do_plain = 1'b0;
		res      = '0;
		mode_d   = mode_q;
		dval_d   = dval_q;
		dcnt_d   = dcnt_q;
		hx       = hex_decode(in_byte);
		acc      = '0;

		unique case (mode_q)
			MODE_ESC: begin
				mode_d = MODE_PLAIN;
				unique case (in_byte)
					CH_LC_A: begin res.slot[n].data = CC_BEL; n = n + 2'd1; end
					CH_LC_B: begin res.slot[n].data = CC_BS;  n = n + 2'd1; end
					CH_LC_F: begin res.slot[n].data = CC_FF;  n = n + 2'd1; end
					CH_LC_N: begin
						res.slot[n].data = CC_LF;
						n = n + 2'd1;
						if (newline_adds_cr) begin
							res.slot[n].data = CC_CR;
							n = n + 2'd1;
						end
					end
					CH_LC_R: begin res.slot[n].data = CC_CR;  n = n + 2'd1; end
					CH_LC_T: begin res.slot[n].data = CC_TAB; n = n + 2'd1; end
					CH_LC_V: begin res.slot[n].data = CC_VT;  n = n + 2'd1; end
					CH_LC_E: begin res.slot[n].data = CC_ESC; n = n + 2'd1; end
					CH_QUOTE: begin res.slot[n].data = CH_QUOTE; n = n + 2'd1; end
					CH_DQUOTE: begin res.slot[n].data = CH_DQUOTE; n = n + 2'd1; end
					CH_LC_X: begin
						mode_d = MODE_HEX0;
					end
					default: begin
						if (is_octal(in_byte)) begin
							dval_d = DIGIT_VALUE_W'(in_byte[2:0]);
							dcnt_d = DIGIT_COUNT_W'(1);
							mode_d = MODE_OCT;
						end else begin
							res.slot[n].data = in_byte;
							n = n + 2'd1;
						end
					end
				endcase
			end
			MODE_CARET: begin
				res.slot[n].data = in_byte & CTRL_MASK;
				n = n + 2'd1;
				mode_d = MODE_PLAIN;
			end
			MODE_OCT: begin
				if (is_octal(in_byte)) begin
					acc    = {dval_q[DIGIT_VALUE_W-4:0], in_byte[2:0]};
					dval_d = acc;
					dcnt_d = dcnt_q + DIGIT_COUNT_W'(1);
					if (dcnt_q == DIGIT_COUNT_W'(2)) begin
						// Third digit completes the escape.
						res.slot[n].data = acc[7:0];
						n = n + 2'd1;
						mode_d = MODE_PLAIN;
						dval_d = '0;
						dcnt_d = '0;
					end
				end else begin
					res.slot[n].data = dval_q[7:0];
					n = n + 2'd1;
					mode_d   = MODE_PLAIN;
					dval_d   = '0;
					dcnt_d   = '0;
					do_plain = 1'b1;
				end
			end
			MODE_HEX0: begin
				if (hx[4]) begin
					dval_d = DIGIT_VALUE_W'(hx[3:0]);
					dcnt_d = DIGIT_COUNT_W'(1);
					mode_d = MODE_HEX1;
				end else begin
					// A bad byte after the x is passed on once and consumed.
					res.slot[n].data = in_byte;
					n = n + 2'd1;
					mode_d = MODE_PLAIN;
					dval_d = '0;
					dcnt_d = '0;
				end
			end
			MODE_HEX1: begin
				mode_d = MODE_PLAIN;
				dval_d = '0;
				dcnt_d = '0;
				if (hx[4]) begin
					res.slot[n].data = {dval_q[3:0], hx[3:0]};
					n = n + 2'd1;
				end else begin
					res.slot[n].data = dval_q[7:0];
					n = n + 2'd1;
					do_plain = 1'b1;
				end
			end
			default: begin
				mode_d   = MODE_PLAIN;
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			if (in_byte == CH_BACKSLASH) begin
				mode_d = MODE_ESC;
			end else if (in_byte == CH_CARET && caret_enable) begin
				mode_d = MODE_CARET;
			end else begin
				res.slot[n].data = in_byte;
				n = n + 2'd1;
			end
		end

		if (in_last) begin
			// Flush pending digits, then close the string with a NUL.
			if (mode_d == MODE_OCT || mode_d == MODE_HEX1) begin
				res.slot[n].data = dval_d[7:0];
				n = n + 2'd1;
			end
			res.slot[n].data = CC_NUL;
			res.slot[n].term = 1'b1;
			n = n + 2'd1;
			mode_d = MODE_PLAIN;
			dval_d = '0;
			dcnt_d = '0;
		end

		if (n != '0) begin
			res.slot[n - 2'd1].run_end = 1'b1;
		end
		res.count = accept ? n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			dval_q <= '0;
			dcnt_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			dval_q <= dval_d;
			dcnt_q <= dcnt_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> mode_q == MODE_PLAIN && dcnt_q == '0 && dval_q == '0)
		else $error("parse state not cleared after the last beat");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |-> res.count != '0)
		else $error("last beat produced no terminator");

endmodule

`default_nettype wire

@@ rtl/core/esd_queue.sv @@
// Output queue of the escape sequence decoder: takes up to three entries per
// cycle and hands them out one beat at a time. Depends on esd_pkg.
`default_nettype none

module esd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire esd_pkg::result_t push,
	output logic                 room,
	output logic                 valid,
	input  wire logic            ready,
	output esd_pkg::entry_t      head
);
	import esd_pkg::*;

	entry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               pop;

	assign valid = cnt_q != '0;
	assign head  = mem_q[rd_ptr_q];
	assign pop   = valid && ready;
	assign room  = cnt_q <= QCNT_W'(QDEPTH - MAX_RESULTS);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (RES_CNT_W'(i) < push.count) begin
				mem_q[wr_ptr_q + QPTR_W'(i)] <= push.slot[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != '0 |-> cnt_q + QCNT_W'(push.count) <= QCNT_W'(QDEPTH))
		else $error("output queue overflow");

	a_term_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid && head.term |-> head.run_end)
		else $error("terminator beat without run end");

endmodule

`default_nettype wire

@@ sim/esd_checker.sv @@
`timescale 1ns / 100ps
// Checker of the escape sequence decoder: watches the input, output and register ports,
// predicts each translated byte and compares it beat by beat. Depends on esd_pkg.

module esd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [7:0]                    out_byte,
	input  logic                          out_run_end,
	input  logic                          out_terminator,
	input  logic                          cfg_wr_en,
	input  logic [esd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data,
	output int unsigned                   mismatches,
	output int unsigned                   awaited,
	output int unsigned                   beats_checked
);
	import esd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       term;
	} out_beat_t;

	out_beat_t expected_q[$];
	out_beat_t staged[$];

	// Shadow copy of the parser and its two register bits.
	mode_t                    parse_state;
	logic [DIGIT_VALUE_W-1:0] acc;
	logic [DIGIT_COUNT_W-1:0] ndig;
	logic                     add_cr;
	logic                     caret_on;

	initial begin
		mismatches    = 0;
		awaited       = 0;
		beats_checked = 0;
	end

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= "0" && c <= "9") begin
			v = c - "0";
		end else if (c >= "a" && c <= "f") begin
			v = c - "a" + 8'd10;
		end else if (c >= "A" && c <= "F") begin
			v = c - "A" + 8'd10;
		end else begin
			return 5'd0;
		end
		return {1'b1, v[3:0]};
	endfunction

	task automatic report(input string msg);
		$display("%0t esd_checker: %s", $time, msg);
		mismatches++;
	endtask

	task automatic push_out(input logic [7:0] d, input logic t);
		out_beat_t e;
		if (staged.size() < MAX_RESULTS) begin
			e.data    = d;
			e.run_end = 1'b0;
			e.term    = t;
			staged.push_back(e);
		end
	endtask

	task automatic clear_digits();
		acc         = '0;
		ndig        = '0;
		parse_state = MODE_PLAIN;
	endtask

	task automatic take_plain(input logic [7:0] c);
		if (c == CH_BACKSLASH) begin
			parse_state = MODE_ESC;
		end else if (c == CH_CARET && caret_on) begin
			parse_state = MODE_CARET;
		end else begin
			push_out(c, 1'b0);
		end
	endtask

	task automatic predict_beat(input logic [7:0] c, input logic l);
		logic [4:0] h;
		out_beat_t  e;
		staged.delete();
		case (parse_state)
			MODE_ESC: begin
				parse_state = MODE_PLAIN;
				case (c)
					CH_LC_A:   push_out(CC_BEL, 1'b0);
					CH_LC_B:   push_out(CC_BS, 1'b0);
					CH_LC_F:   push_out(CC_FF, 1'b0);
					CH_LC_N: begin
						push_out(CC_LF, 1'b0);
						if (add_cr) push_out(CC_CR, 1'b0);
					end
					CH_LC_R:   push_out(CC_CR, 1'b0);
					CH_LC_T:   push_out(CC_TAB, 1'b0);
					CH_LC_V:   push_out(CC_VT, 1'b0);
					CH_QUOTE:  push_out(CH_QUOTE, 1'b0);
					CH_DQUOTE: push_out(CH_DQUOTE, 1'b0);
					CH_LC_E:   push_out(CC_ESC, 1'b0);
					CH_LC_X:   parse_state = MODE_HEX0;
					default: begin
						if (c >= "0" && c <= "7") begin
							acc         = DIGIT_VALUE_W'(c - "0");
							ndig        = 2'd1;
							parse_state = MODE_OCT;
						end else begin
							push_out(c, 1'b0);
						end
					end
				endcase
			end
			MODE_CARET: begin
				push_out(c & CTRL_MASK, 1'b0);
				parse_state = MODE_PLAIN;
			end
			MODE_OCT: begin
				if (c >= "0" && c <= "7") begin
					acc  = (acc << 3) + (c - "0");
					ndig = ndig + 1'b1;
					if (ndig == 2'd3) begin
						push_out(acc[7:0], 1'b0);
						clear_digits();
					end
				end else begin
					push_out(acc[7:0], 1'b0);
					clear_digits();
					take_plain(c);
				end
			end
			MODE_HEX0: begin
				h = hex_val(c);
				if (h[4]) begin
					acc         = DIGIT_VALUE_W'(h[3:0]);
					ndig        = 2'd1;
					parse_state = MODE_HEX1;
				end else begin
					push_out(c, 1'b0);
					clear_digits();
				end
			end
			MODE_HEX1: begin
				h = hex_val(c);
				if (h[4]) begin
					push_out({acc[3:0], h[3:0]}, 1'b0);
					clear_digits();
				end else begin
					push_out(acc[7:0], 1'b0);
					clear_digits();
					take_plain(c);
				end
			end
			default: begin
				parse_state = MODE_PLAIN;
				take_plain(c);
			end
		endcase

		if (l) begin
			if (parse_state == MODE_OCT || parse_state == MODE_HEX1) push_out(acc[7:0], 1'b0);
			push_out(CC_NUL, 1'b1);
			clear_digits();
		end

		if (staged.size() > 0) begin
			e = staged.pop_back();
			e.run_end = 1'b1;
			staged.push_back(e);
		end
		foreach (staged[i]) expected_q.push_back(staged[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t e;
		if (!arst_n) begin
			clear_digits();
			add_cr   = 1'b1;
			caret_on = 1'b1;
			expected_q.delete();
			awaited <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_NEWLINE_ADDS_CR: add_cr = cfg_data;
					CFG_CARET_ENABLE:    caret_on = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_beat(in_byte, in_last);
			if (out_valid && out_ready) begin
				beats_checked++;
				if (expected_q.size() == 0) begin
					report($sformatf("output beat 0x%02h with nothing expected", out_byte));
				end else begin
					e = expected_q.pop_front();
					if (out_byte !== e.data)
						report($sformatf("out_byte 0x%02h, expected 0x%02h", out_byte, e.data));
					if (out_run_end !== e.run_end)
						report($sformatf("out_run_end %b, expected %b", out_run_end, e.run_end));
					if (out_terminator !== e.term)
						report($sformatf("out_terminator %b, expected %b", out_terminator, e.term));
				end
			end
			awaited <= expected_q.size();
		end
	end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Top of the escape sequence decoder testbench: clock, reset, stimulus and verdict.
// Depends on esd_pkg, escape_sequence_decoder and esd_checker.

module tb;
	import esd_pkg::*;

	localparam int unsigned LIMIT       = 400000;
	localparam int unsigned SETTLE      = 4;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned PHASE_BEATS = 33;

	// Register index that names no register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	// Register settings per random phase, bit p for phase p: the four
	// combinations of the two bits, so both extremes of each are visited.
	localparam logic [3:0] NL_BY_PHASE    = 4'b1010;
	localparam logic [3:0] CARET_BY_PHASE = 4'b1001;

	logic                 clk;
	logic                 arst_n         = 1'b0;
	logic                 in_valid       = 1'b0;
	logic                 in_ready;
	logic [7:0]           in_byte        = 8'h00;
	logic                 in_last        = 1'b0;
	logic                 out_valid;
	logic                 out_ready      = 1'b0;
	logic [7:0]           out_byte;
	logic                 out_run_end;
	logic                 out_terminator;
	logic                 cfg_wr_en      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic                 cfg_data       = 1'b0;

	int unsigned mismatches;
	int unsigned awaited;
	int unsigned beats_checked;

	int unsigned cycles        = 0;
	int unsigned beats_sent    = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_req      = 1'b0;
	string       hex_chars     = "0123456789abcdefABCDEF";

	escape_sequence_decoder DUT (.*);
	esd_checker CHECK (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: a hung handshake or a lost beat ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: run stopped after %0d cycles with %0d beats still awaited",
				cycles, awaited);
			$display("tb: FAIL");
			$finish;
		end
	end

	// Receiver. Drops out_ready at random per cycle at the current idle rate,
	// or, on a long hold request, keeps it low for a span set by HOLD_CYCLES
	// so that the output queue fills and the block refuses input beats.
	initial begin
		int held;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one input beat and returns at the edge that accepts it. Valid is
	// left high so that back-to-back beats run without a gap; an idle cycle
	// lowers it in a later time step than the one that raised it.
	task automatic send_beat(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		beats_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	// One byte of a random string; now and then it closes the string, which
	// also cuts off whatever escape happens to be open at that point.
	task automatic put_byte(input logic [7:0] b);
		send_beat(b, $urandom_range(11) == 0);
	endtask

	// Starts with an edge so that two writes in a row never assign the
	// write enable twice in one time step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Waits until every predicted beat has come out, then a settling time set
	// by SETTLE, since a beat such as a lone backslash leaves the parser busy
	// with no output to show for it.
	task automatic wait_idle();
		do @(posedge clk); while (awaited != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One random token. Most are well-formed escapes with random content;
	// the rest are raw bytes and escapes followed by arbitrary bytes.
	task automatic send_token();
		int         kind;
		int         n;
		logic [7:0] esc_letters [10];
		esc_letters = '{CH_LC_A, CH_LC_B, CH_LC_F, CH_LC_N, CH_LC_R,
			CH_LC_T, CH_LC_V, CH_QUOTE, CH_DQUOTE, CH_LC_E};
		kind = $urandom_range(99);
		if (kind < 15) begin
			put_byte(8'($urandom_range(255)));
		end else if (kind < 35) begin
			put_byte(CH_BACKSLASH);
			put_byte(esc_letters[$urandom_range(9)]);
		end else if (kind < 55) begin
			put_byte(CH_BACKSLASH);
			n = $urandom_range(3, 1);
			repeat (n) put_byte(8'("0" + $urandom_range(7)));
		end else if (kind < 75) begin
			// Zero digits leaves the next token's first byte to follow the x.
			put_byte(CH_BACKSLASH);
			put_byte(CH_LC_X);
			n = $urandom_range(2);
			repeat (n) put_byte(hex_chars[$urandom_range(21)]);
		end else if (kind < 87) begin
			put_byte(CH_CARET);
			put_byte(8'($urandom_range(255)));
		end else begin
			put_byte(CH_BACKSLASH);
			put_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int p;
		int unsigned phase_start;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, with both register bits set. The write to the unused
		// index must leave them alone, which the escaped n below shows.
		send_idle_pct = 9;
		recv_idle_pct = 50;
		write_reg(CFG_NEWLINE_ADDS_CR, 1'b1);
		write_reg(CFG_CARET_ENABLE, 1'b1);
		write_reg(CFG_UNUSED_IDX, 1'b0);

		send_beat(8'h00, 1'b0);             // NUL and 0xFF are plain data
		send_beat(8'hFF, 1'b0);
		send_beat(CH_BACKSLASH, 1'b0);      // newline expands to LF and CR
		send_beat(CH_LC_N, 1'b0);
		send_beat(CH_BACKSLASH, 1'b0);      // full three-digit octal
		send_beat("1", 1'b0);
		send_beat("0", 1'b0);
		send_beat("1", 1'b0);
		send_beat(CH_BACKSLASH, 1'b0);      // octal cut short by a letter
		send_beat("7", 1'b0);
		send_beat("Z", 1'b0);
		send_beat(CH_BACKSLASH, 1'b0);      // non-hex byte straight after x
		send_beat(CH_LC_X, 1'b0);
		send_beat("G", 1'b0);
		send_beat(CH_BACKSLASH, 1'b0);      // two hex digits, mixed case
		send_beat(CH_LC_X, 1'b0);
		send_beat("f", 1'b0);
		send_beat("F", 1'b0);
		send_beat(CH_CARET, 1'b0);          // control character
		send_beat("?", 1'b0);
		send_beat(CH_BACKSLASH, 1'b0);      // unknown escape loses its backslash
		send_beat("q", 1'b0);
		send_beat(CH_BACKSLASH, 1'b0);      // pending octal flushed by the last beat
		send_beat("3", 1'b1);
		send_beat(CH_CARET, 1'b1);          // dangling caret is dropped
		send_beat(CH_CARET, 1'b0);          // caret left open across a write
		in_valid <= 1'b0;
		wait_idle();

		// Turning the caret off must not stop the sequence already started.
		write_reg(CFG_CARET_ENABLE, 1'b0);
		send_beat("A", 1'b1);
		in_valid <= 1'b0;
		wait_idle();

		// Random phases, one per register setting. The idle pattern moves from
		// a slow receiver to a slow sender and then to none at all; the last
		// phase opens with a long receiver hold while the sender keeps going.
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(CFG_NEWLINE_ADDS_CR, NL_BY_PHASE[p]);
			write_reg(CFG_CARET_ENABLE, CARET_BY_PHASE[p]);
			if (p == 3) hold_req = 1'b1;
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) send_token();
			// Close the string so the parser is back in plain text before the
			// next register write.
			send_beat(8'($urandom_range(255)), 1'b1);
			in_valid <= 1'b0;
			wait_idle();
		end

		repeat (16) @(posedge clk);
		$display("tb: %0d input beats sent under all four register settings and three idle",
			beats_sent);
		$display("tb: patterns with a long output hold; %0d output beats compared",
			beats_checked);
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
